>>> rtl/heq_pkg.sv
// Package for the histogram equalizer: sequencer states and mode codes.
// No dependencies.
package heq_pkg;

  typedef enum logic [1:0] {
    MODE_COUNT = 2'd0,
    MODE_BUILD = 2'd1,
    MODE_REMAP = 2'd2,
    MODE_CLEAR = 2'd3
  } heq_mode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT_WR,
    ST_MAP_OUT,
    ST_ZERO,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_ACC_RD,
    ST_ACC_ADD,
    ST_DIV
  } heq_state_e;

endpackage

>>> rtl/heq_div.sv
// Iterative restoring divider, one quotient bit per cycle, quotient below 2^(PIXEL_BITS+1).
// Depends on nothing outside this file.
module heq_div #(
  parameter int PIXEL_BITS = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [COUNT_BITS+PIXEL_BITS+1:0] num_i,
  input  logic [COUNT_BITS:0]            den_i,
  output logic                           done_o,
  output logic [PIXEL_BITS:0]            quo_o
);
  localparam int CW = $clog2(PIXEL_BITS + 2);

  logic [COUNT_BITS+1:0] r_q, r_d, rs;
  logic [PIXEL_BITS:0]   qs_q, qs_d;
  logic [COUNT_BITS:0]   den_q;
  logic [CW-1:0]         cnt_q;
  logic                  busy_q, done_q, ge;

  always_comb begin
    rs   = {r_q[COUNT_BITS:0], qs_q[PIXEL_BITS]};
    ge   = rs >= {1'b0, den_q};
    r_d  = ge ? (rs - {1'b0, den_q}) : rs;
    qs_d = {qs_q[PIXEL_BITS-1:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(PIXEL_BITS + 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= {1'b0, num_i[COUNT_BITS+PIXEL_BITS+1:PIXEL_BITS+1]};
      qs_q  <= num_i[PIXEL_BITS:0];
      den_q <= den_i;
    end else if (busy_q) begin
      r_q  <= r_d;
      qs_q <= qs_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = qs_q;

endmodule

>>> rtl/histogram_equalizer_16bit.sv
// Histogram equalizer top level: sequencer, histogram and mapping memories.
// Depends on heq_pkg and heq_div.
//
// After reset the block sweeps the histogram to zero, one bin a cycle, before
// in_ready_o rises; clear mode runs the same sweep. A count beat reads the bin,
// then writes it back; when the pixel is below the cut-off the bin is not
// written back. A remap beat reads the mapping table, then loads the output
// register once it is free. A build beat first zeroes the mapping table,
// scans for the first nonzero bin above bin 0 (a read and a check per bin
// scanned), then for each higher bin reads it, adds it to the running sum and
// waits on the divider, which yields one quotient bit a cycle. Only one beat is
// in work at a time; a finished remap result waits in the output register.
module histogram_equalizer_16bit #(
  parameter int PIXEL_BITS = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] pixel_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] pixel_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_min_level_i
);
  import heq_pkg::*;

  localparam int NB = 1 << PIXEL_BITS;
  localparam int NW = COUNT_BITS + PIXEL_BITS + 2;

  heq_state_e state_q, state_d;

  logic [PIXEL_BITS-1:0] b_q, b_d, pix_q, pix_d, pix;
  logic [COUNT_BITS-1:0] total_q, total_d, div_q, div_d, sum_q, sum_d;
  logic [15:0]           min_q, out_q, out_d;
  logic                  out_valid_q, out_valid_d, cut_q, cut_d;
  logic                  in_fire, last, below;
  logic [COUNT_BITS:0]   ssum;
  logic [COUNT_BITS-1:0] ssat;
  logic [NW-1:0]         num;
  logic                  div_start, div_done;
  logic [PIXEL_BITS:0]   quo;

  logic [COUNT_BITS-1:0] bin_mem [NB];
  logic [COUNT_BITS-1:0] bin_rdata_q, bin_wdata;
  logic [PIXEL_BITS-1:0] bin_raddr, bin_waddr;
  logic                  bin_rd_en, bin_we;

  logic [PIXEL_BITS-1:0] map_mem [NB];
  logic [PIXEL_BITS-1:0] map_rdata_q, map_wdata, map_raddr, map_waddr;
  logic                  map_rd_en, map_we;

  assign pix         = pixel_in_i[PIXEL_BITS-1:0];
  assign below       = 16'(pix) < min_q;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign last        = &b_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_q;

  assign ssum = {1'b0, sum_q} + {1'b0, bin_rdata_q};
  assign ssat = (ssum > {1'b0, div_q}) ? div_q : ssum[COUNT_BITS-1:0];
  assign num  = (NW'(ssat) << (PIXEL_BITS + 1)) - (NW'(ssat) << 1) + NW'(div_q);

  heq_div #(
    .PIXEL_BITS(PIXEL_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num),
    .den_i  ({div_q, 1'b0}),
    .done_o (div_done),
    .quo_o  (quo)
  );

  always_comb begin
    state_d     = state_q;
    b_d         = b_q;
    pix_d       = pix_q;
    cut_d       = cut_q;
    total_d     = total_q;
    div_d       = div_q;
    sum_d       = sum_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    bin_rd_en   = 1'b0;
    bin_raddr   = b_q;
    bin_we      = 1'b0;
    bin_waddr   = b_q;
    bin_wdata   = '0;
    map_rd_en   = 1'b0;
    map_raddr   = pix;
    map_we      = 1'b0;
    map_waddr   = b_q;
    map_wdata   = '0;
    div_start   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        bin_we = 1'b1;
        b_d    = b_q + 1'b1;
        if (last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          pix_d = pix;
          cut_d = below;
          case (heq_mode_e'(mode_i))
            MODE_COUNT: begin
              bin_rd_en = 1'b1;
              bin_raddr = pix;
              if (!below) begin
                state_d = ST_CNT_WR;
              end
            end
            MODE_REMAP: begin
              map_rd_en = 1'b1;
              state_d   = ST_MAP_OUT;
            end
            MODE_BUILD: begin
              b_d     = '0;
              state_d = ST_ZERO;
            end
            MODE_CLEAR: begin
              b_d     = '0;
              total_d = '0;
              state_d = ST_CLEAR;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CNT_WR: begin
        bin_we    = 1'b1;
        bin_waddr = pix_q;
        bin_wdata = (&bin_rdata_q) ? bin_rdata_q : bin_rdata_q + 1'b1;
        total_d   = (&total_q) ? total_q : total_q + 1'b1;
        state_d   = ST_IDLE;
      end
      ST_MAP_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = cut_q ? 16'd0 : 16'(map_rdata_q);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_ZERO: begin
        map_we = 1'b1;
        b_d    = b_q + 1'b1;
        if (last) begin
          b_d     = PIXEL_BITS'(1);
          state_d = ST_FIND_RD;
        end
      end
      ST_FIND_RD: begin
        bin_rd_en = 1'b1;
        state_d   = ST_FIND_CHK;
      end
      ST_FIND_CHK: begin
        if (bin_rdata_q != '0) begin
          div_d = total_q - bin_rdata_q;
          sum_d = '0;
          b_d   = b_q + 1'b1;
          if (total_q <= bin_rdata_q || last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_ACC_RD;
          end
        end else if (last) begin
          state_d = ST_IDLE;
        end else begin
          b_d     = b_q + 1'b1;
          state_d = ST_FIND_RD;
        end
      end
      ST_ACC_RD: begin
        bin_rd_en = 1'b1;
        state_d   = ST_ACC_ADD;
      end
      ST_ACC_ADD: begin
        sum_d     = ssat;
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          map_we    = 1'b1;
          map_wdata = quo[PIXEL_BITS] ? '1 : quo[PIXEL_BITS-1:0];
          b_d       = b_q + 1'b1;
          state_d   = last ? ST_IDLE : ST_ACC_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      b_q         <= '0;
      total_q     <= '0;
      min_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      b_q         <= b_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        min_q <= cfg_min_level_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
    cut_q <= cut_d;
    div_q <= div_d;
    sum_q <= sum_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (bin_we) begin
      bin_mem[bin_waddr] <= bin_wdata;
    end
    if (bin_rd_en) begin
      bin_rdata_q <= bin_mem[bin_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_rd_en) begin
      map_rdata_q <= map_mem[map_raddr];
    end
  end

endmodule

>>> tb/sv/histogram_equalizer_16bit_test.sv
// Self-checking testbench for histogram_equalizer_16bit: counts, table builds,
// remaps and clears against a predictor held in a small scoreboard class.
// Depends on heq_pkg and the histogram_equalizer_16bit RTL.
module histogram_equalizer_16bit_test;
  import heq_pkg::*;

  localparam int NBINS = 65536;
  localparam int HIGH_FLOOR = 65000;

  class heq_scoreboard;
    bit [31:0] bin_cnt [NBINS];
    bit [31:0] pix_total;
    bit [15:0] eq_map [NBINS];
    bit [15:0] min_level;
    bit [15:0] pending_pix [$];
    int errors;

    function new();
      pix_total = 0;
      min_level = 0;
      errors = 0;
      foreach (bin_cnt[i]) bin_cnt[i] = 0;
      foreach (eq_map[i]) eq_map[i] = 0;
    endfunction

    function void build_map();
      int first;
      longint unsigned dv;
      longint unsigned run;
      longint unsigned q;
      first = 1;
      foreach (eq_map[i]) eq_map[i] = 0;
      while (first < NBINS && bin_cnt[first] == 0) first++;
      if (first >= NBINS) return;
      if (pix_total <= bin_cnt[first]) return;
      dv = pix_total - bin_cnt[first];
      run = 0;
      for (int b = first + 1; b < NBINS; b++) begin
        run += bin_cnt[b];
        if (run > dv) run = dv;
        q = (2 * run * 65535 + dv) / (2 * dv);
        if (q > 65535) q = 65535;
        eq_map[b] = q[15:0];
      end
    endfunction

    function void note_beat(heq_mode_e m, bit [15:0] p);
      case (m)
        MODE_COUNT: begin
          if (p >= min_level) begin
            if (bin_cnt[p] != 32'hFFFF_FFFF) bin_cnt[p]++;
            if (pix_total != 32'hFFFF_FFFF) pix_total++;
          end
        end
        MODE_BUILD: build_map();
        MODE_REMAP: pending_pix = {pending_pix, ((p >= min_level) ? eq_map[p] : 16'd0)};
        default: begin
          foreach (bin_cnt[i]) bin_cnt[i] = 0;
          pix_total = 0;
        end
      endcase
    endfunction

    function void check_pixel(bit [15:0] got);
      bit [15:0] want;
      if (pending_pix.size() == 0) begin
        $error("pixel_out: no result expected, got %0d", got);
        errors++;
        return;
      end
      want = pending_pix.pop_front();
      if (got !== want) begin
        $error("pixel_out: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = MODE_COUNT;
  logic [15:0] pixel_in_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] pixel_out_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_min_level_i = '0;

  heq_scoreboard sb = new();
  int beats_sent = 0;
  int results_seen = 0;

  histogram_equalizer_16bit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .mode_i(mode_i), .pixel_in_i(pixel_in_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .pixel_out_o(pixel_out_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_min_level_i(cfg_min_level_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_beat(heq_mode_e m, bit [15:0] p);
    bit calm;
    calm = (beats_sent >= 300 && beats_sent < 450);
    if (!calm && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    pixel_in_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beat(m, p);
    beats_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_pix.size() != 0 || !in_ready_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_level(bit [15:0] lvl);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_min_level_i <= lvl;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.min_level = lvl;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // count pixels stay high, at zero or below the level so table builds stay short
  function automatic bit [15:0] count_pixel(bit [15:0] lvl);
    int r;
    bit [15:0] p;
    r = $urandom_range(99);
    if (r < 60) return 16'($urandom_range(65535, HIGH_FLOOR));
    if (r < 75) return 16'd0;
    p = 16'($urandom);
    if (p >= lvl && p < HIGH_FLOOR && p != 0) p = 16'($urandom_range(65535, HIGH_FLOOR));
    return p;
  endfunction

  task automatic random_beats(int n);
    int done;
    bit [15:0] p;
    done = 0;
    while (done < n) begin
      if ($urandom_range(99) < 55) begin
        p = count_pixel(sb.min_level);
        send_beat(MODE_COUNT, p);
      end else begin
        send_beat(MODE_REMAP, 16'($urandom));
      end
      done++;
    end
  endtask

  initial begin
    bit [15:0] remap_set [6];
    remap_set = '{16'd0, 16'd65535, 16'd65100, 16'hAAAA, 16'h5555, 16'd65300};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);

    write_level(16'd0);
    send_beat(MODE_BUILD, 16'd0);
    foreach (remap_set[i]) send_beat(MODE_REMAP, remap_set[i]);
    repeat (3) send_beat(MODE_COUNT, 16'd65100);
    send_beat(MODE_BUILD, 16'hFFFF);
    send_beat(MODE_REMAP, 16'd65535);
    repeat (3) send_beat(MODE_COUNT, 16'd0);
    send_beat(MODE_COUNT, 16'd65200);
    send_beat(MODE_COUNT, 16'd65535);
    send_beat(MODE_BUILD, 16'd0);
    foreach (remap_set[i]) send_beat(MODE_REMAP, remap_set[i]);
    send_beat(MODE_CLEAR, 16'h1234);

    write_level(16'd65535);
    send_beat(MODE_COUNT, 16'd65535);
    send_beat(MODE_COUNT, 16'd65534);
    send_beat(MODE_REMAP, 16'd65534);
    send_beat(MODE_REMAP, 16'd65535);

    write_level(16'd64000);
    random_beats(400);
    send_beat(MODE_BUILD, 16'($urandom));
    random_beats(400);

    settle();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_pixel(pixel_out_o);
        results_seen++;
        if (results_seen == 100) hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (results_seen >= 200 && results_seen < 350) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 27);
      end
    end
  end

endmodule
